[rtl/afit_pkg.sv]
// Shared constants and types of the affine least-squares fit block.
`default_nettype none
package afit_pkg;
    localparam int COORD_BITS = 12;
    localparam int MAX_POINTS = 1024;
    localparam int FRAC_BITS  = 16;
    localparam int IN_W       = 12;
    localparam int OUT_W      = 32;
    localparam int LOG_N      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int SUM_W      = 2 * COORD_BITS + LOG_N;
    localparam int LIN_W      = COORD_BITS + LOG_N;
    localparam int MIN_W      = 2 * SUM_W + 1;
    localparam int DET_W      = 3 * SUM_W + 3;
    localparam int MAG_W      = DET_W - 1;
    localparam int NUM_W      = MAG_W + FRAC_BITS;
    localparam int STEP_W     = $clog2(NUM_W);
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic                  take;
        logic                  last;
        logic [COORD_BITS-1:0] sx;
        logic [COORD_BITS-1:0] sy;
        logic [COORD_BITS-1:0] dx;
        logic [COORD_BITS-1:0] dy;
    } t_item;

    typedef struct packed {
        logic [SUM_W-1:0] syy;
        logic [SUM_W-1:0] sxy;
        logic [SUM_W-1:0] sxx;
        logic [LIN_W-1:0] sy;
        logic [LIN_W-1:0] sx;
        logic [CNT_W-1:0] n;
        logic [SUM_W-1:0] dy_sy;
        logic [SUM_W-1:0] dy_sx;
        logic [LIN_W-1:0] dy;
        logic [SUM_W-1:0] dx_sy;
        logic [SUM_W-1:0] dx_sx;
        logic [LIN_W-1:0] dx;
        logic             ovf;
    } t_fit;
endpackage
`default_nettype wire

[rtl/afit_front.sv]
// Intake: accepts transactions, counts pairs and marks each as kept or dropped.
`default_nettype none
module afit_front (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_ready,
    input  wire [afit_pkg::IN_W-1:0] i_src_x,
    input  wire [afit_pkg::IN_W-1:0] i_src_y,
    input  wire [afit_pkg::IN_W-1:0] i_dst_x,
    input  wire [afit_pkg::IN_W-1:0] i_dst_y,
    input  wire                    i_last_pair,
    input  wire                    i_full,
    output logic                   o_push,
    output afit_pkg::t_item        o_item
);
    logic [afit_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic take;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;
    assign take    = r_cnt < afit_pkg::CNT_W'(afit_pkg::MAX_POINTS);

    always_comb begin
        o_item.take = take;
        o_item.last = i_last_pair;
        o_item.sx   = i_src_x[afit_pkg::COORD_BITS-1:0];
        o_item.sy   = i_src_y[afit_pkg::COORD_BITS-1:0];
        o_item.dx   = i_dst_x[afit_pkg::COORD_BITS-1:0];
        o_item.dy   = i_dst_y[afit_pkg::COORD_BITS-1:0];
        n_cnt = r_cnt;
        if (o_push) begin
            if (i_last_pair) begin
                n_cnt = '0;
            end else if (take) begin
                n_cnt = r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end
endmodule
`default_nettype wire

[rtl/afit_fifo.sv]
// Short queue of classified pairs between intake and accumulation.
`default_nettype none
module afit_fifo (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  afit_pkg::t_item  i_item,
    output logic             o_full,
    input  wire              i_pop,
    output logic             o_valid,
    output afit_pkg::t_item  o_item
);
    afit_pkg::t_item r_mem [afit_pkg::FIFO_DEPTH];
    logic [afit_pkg::FIFO_AW-1:0] r_wp, r_rp;
    logic [afit_pkg::FIFO_CW-1:0] r_cnt;

    assign o_full  = r_cnt == afit_pkg::FIFO_CW'(afit_pkg::FIFO_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

[rtl/afit_acc.sv]
// Normal-equation accumulation; hands the finished sums to the solver.
`default_nettype none
module afit_acc (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    input  afit_pkg::t_item  i_item,
    output logic             o_pop,
    input  wire              i_idle,
    output logic             o_start,
    output afit_pkg::t_fit   o_fit
);
    afit_pkg::t_fit r_fit, n_fit;
    logic [2*afit_pkg::COORD_BITS-1:0] p_yy, p_xy, p_xx, p_dysy, p_dysx, p_dxsy, p_dxsx;

    assign o_pop   = i_valid && (!i_item.last || i_idle);
    assign o_start = o_pop && i_item.last;
    assign o_fit   = n_fit;

    always_comb begin
        p_yy   = i_item.sy * i_item.sy;
        p_xy   = i_item.sx * i_item.sy;
        p_xx   = i_item.sx * i_item.sx;
        p_dysy = i_item.dy * i_item.sy;
        p_dysx = i_item.dy * i_item.sx;
        p_dxsy = i_item.dx * i_item.sy;
        p_dxsx = i_item.dx * i_item.sx;
        n_fit = r_fit;
        if (i_item.take) begin
            n_fit.syy   = r_fit.syy + afit_pkg::SUM_W'(p_yy);
            n_fit.sxy   = r_fit.sxy + afit_pkg::SUM_W'(p_xy);
            n_fit.sxx   = r_fit.sxx + afit_pkg::SUM_W'(p_xx);
            n_fit.sy    = r_fit.sy + afit_pkg::LIN_W'(i_item.sy);
            n_fit.sx    = r_fit.sx + afit_pkg::LIN_W'(i_item.sx);
            n_fit.n     = r_fit.n + 1'b1;
            n_fit.dy_sy = r_fit.dy_sy + afit_pkg::SUM_W'(p_dysy);
            n_fit.dy_sx = r_fit.dy_sx + afit_pkg::SUM_W'(p_dysx);
            n_fit.dy    = r_fit.dy + afit_pkg::LIN_W'(i_item.dy);
            n_fit.dx_sy = r_fit.dx_sy + afit_pkg::SUM_W'(p_dxsy);
            n_fit.dx_sx = r_fit.dx_sx + afit_pkg::SUM_W'(p_dxsx);
            n_fit.dx    = r_fit.dx + afit_pkg::LIN_W'(i_item.dx);
        end else begin
            n_fit.ovf = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit <= '0;
        end else if (o_pop) begin
            r_fit <= i_item.last ? '0 : n_fit;
        end
    end
endmodule
`default_nettype wire

[rtl/afit_solve.sv]
// Cramer solve with a shift-add multiplier and a restoring divider, plus output register.
`default_nettype none
module afit_solve (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_start,
    input  afit_pkg::t_fit                 i_fit,
    output logic                           o_idle,
    output logic                           o_valid,
    input  wire                            i_ready,
    output logic signed [afit_pkg::OUT_W-1:0] o_coef [6],
    output logic                           o_singular,
    output logic                           o_overflow,
    output logic                           o_saturated
);
    localparam int SW = afit_pkg::SUM_W;
    localparam int DW = afit_pkg::DET_W;
    localparam int MW = afit_pkg::MAG_W;
    localparam int NW = afit_pkg::NUM_W;
    localparam int QW = NW + 1;
    localparam logic [3:0] OP_LAST = 4'd8;
    localparam logic [3:0] OP_C0   = 4'd1;
    localparam logic [3:0] OP_C1   = 4'd3;
    localparam logic [3:0] OP_C2   = 4'd5;
    localparam logic [2:0] JOB_DET  = 3'd0;
    localparam logic [2:0] JOB_LAST = 3'd6;
    localparam logic [QW-1:0] LIM_NEG = QW'({1'b1, {(afit_pkg::OUT_W-1){1'b0}}});
    localparam logic [QW-1:0] LIM_POS = LIM_NEG - 1'b1;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_LOAD = 6'b000010,
        S_MUL  = 6'b000100,
        S_DIV  = 6'b001000,
        S_RND  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state r_state, n_state;
    afit_pkg::t_fit r_fit, n_fit;
    logic [2:0] r_job, n_job;
    logic [3:0] r_op, n_op;
    logic [afit_pkg::STEP_W-1:0] r_cnt, n_cnt;
    logic signed [DW-1:0] r_acc, n_acc, r_ma, n_ma, r_det, n_det;
    logic [SW-1:0] r_mb, n_mb;
    logic signed [afit_pkg::MIN_W-1:0] r_c0, n_c0, r_c1, n_c1, r_c2, n_c2;
    logic r_neg, n_neg;
    logic [NW-1:0] r_num, n_num, r_q, n_q;
    logic [MW-1:0] r_den, n_den, r_rem, n_rem;
    logic signed [afit_pkg::OUT_W-1:0] r_coef [6];
    logic signed [afit_pkg::OUT_W-1:0] n_coef [6];
    logic r_sing, n_sing, r_sat, n_sat;

    logic signed [DW-1:0] a_val, acc_sum, num_abs, det_abs;
    logic [MW:0] rs;
    logic ge, rnd;
    logic [QW-1:0] q1, lim, mag;
    logic [afit_pkg::OUT_W-1:0] res;

    function automatic logic [SW-1:0] elem(input afit_pkg::t_fit f, input logic [3:0] e,
                                           input logic [2:0] job);
        logic [SW-1:0] v;
        logic [1:0] row, col, jcol;
        logic [SW-1:0] b0, b1, b2;
        v = '0;
        row = 2'd0;
        col = 2'd0;
        case (e)
            4'd0: begin v = f.syy;       row = 2'd0; col = 2'd0; end
            4'd1: begin v = f.sxy;       row = 2'd0; col = 2'd1; end
            4'd2: begin v = SW'(f.sy);   row = 2'd0; col = 2'd2; end
            4'd3: begin v = f.sxy;       row = 2'd1; col = 2'd0; end
            4'd4: begin v = f.sxx;       row = 2'd1; col = 2'd1; end
            4'd5: begin v = SW'(f.sx);   row = 2'd1; col = 2'd2; end
            4'd6: begin v = SW'(f.sy);   row = 2'd2; col = 2'd0; end
            4'd7: begin v = SW'(f.sx);   row = 2'd2; col = 2'd1; end
            4'd8: begin v = SW'(f.n);    row = 2'd2; col = 2'd2; end
            default: begin v = '0; end
        endcase
        case (job)
            3'd1, 3'd4: jcol = 2'd0;
            3'd2, 3'd5: jcol = 2'd1;
            3'd3, 3'd6: jcol = 2'd2;
            default:    jcol = 2'd3;
        endcase
        if (job > 3'd3) begin
            b0 = f.dx_sy;
            b1 = f.dx_sx;
            b2 = SW'(f.dx);
        end else begin
            b0 = f.dy_sy;
            b1 = f.dy_sx;
            b2 = SW'(f.dy);
        end
        if (col == jcol) begin
            case (row)
                2'd0:    v = b0;
                2'd1:    v = b1;
                default: v = b2;
            endcase
        end
        return v;
    endfunction

    function automatic logic [3:0] a_idx(input logic [3:0] op);
        case (op)
            4'd0:    return 4'd4;
            4'd1:    return 4'd5;
            4'd2:    return 4'd3;
            4'd3:    return 4'd5;
            4'd4:    return 4'd3;
            4'd5:    return 4'd4;
            default: return 4'd0;
        endcase
    endfunction

    function automatic logic [3:0] b_idx(input logic [3:0] op);
        case (op)
            4'd0:    return 4'd8;
            4'd1:    return 4'd7;
            4'd2:    return 4'd8;
            4'd3:    return 4'd6;
            4'd4:    return 4'd7;
            4'd5:    return 4'd6;
            4'd6:    return 4'd0;
            4'd7:    return 4'd1;
            default: return 4'd2;
        endcase
    endfunction

    assign o_idle      = r_state == S_IDLE;
    assign o_valid     = r_state == S_DONE;
    assign o_coef      = r_coef;
    assign o_singular  = r_sing;
    assign o_overflow  = r_fit.ovf;
    assign o_saturated = r_sat;

    always_comb begin
        n_state = r_state;
        n_fit = r_fit;
        n_job = r_job;
        n_op = r_op;
        n_cnt = r_cnt;
        n_acc = r_acc;
        n_ma = r_ma;
        n_mb = r_mb;
        n_det = r_det;
        n_c0 = r_c0;
        n_c1 = r_c1;
        n_c2 = r_c2;
        n_neg = r_neg;
        n_num = r_num;
        n_den = r_den;
        n_rem = r_rem;
        n_q = r_q;
        n_coef = r_coef;
        n_sing = r_sing;
        n_sat = r_sat;

        case (r_op)
            4'd6:    a_val = DW'(r_c0);
            4'd7:    a_val = DW'(r_c1);
            4'd8:    a_val = DW'(r_c2);
            default: a_val = DW'(elem(r_fit, a_idx(r_op), r_job));
        endcase
        acc_sum = r_acc + (r_mb[0] ? r_ma : '0);
        num_abs = acc_sum[DW-1] ? -acc_sum : acc_sum;
        det_abs = r_det[DW-1] ? -r_det : r_det;
        rs  = {r_rem, r_num[NW-1]};
        ge  = rs >= {1'b0, r_den};
        rnd = {r_rem, 1'b0} >= {1'b0, r_den};
        q1  = {1'b0, r_q} + QW'(rnd);
        lim = r_neg ? LIM_NEG : LIM_POS;
        mag = (q1 > lim) ? lim : q1;
        res = r_neg ? -mag[afit_pkg::OUT_W-1:0] : mag[afit_pkg::OUT_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_fit = i_fit;
                    n_job = JOB_DET;
                    n_op = '0;
                    n_sing = 1'b0;
                    n_sat = 1'b0;
                    for (int k = 0; k < 6; k++) begin
                        n_coef[k] = '0;
                    end
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_ma = (r_op[0] && r_op != OP_LAST) ? -a_val : a_val;
                n_mb = elem(r_fit, b_idx(r_op), r_job);
                if (r_op inside {4'd0, 4'd2, 4'd4, 4'd6}) begin
                    n_acc = '0;
                end
                n_cnt = '0;
                n_state = S_MUL;
            end
            S_MUL: begin
                n_acc = acc_sum;
                n_ma = r_ma <<< 1;
                n_mb = r_mb >> 1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == afit_pkg::STEP_W'(SW - 1)) begin
                    case (r_op)
                        OP_C0:   n_c0 = afit_pkg::MIN_W'(acc_sum);
                        OP_C1:   n_c1 = afit_pkg::MIN_W'(acc_sum);
                        OP_C2:   n_c2 = afit_pkg::MIN_W'(acc_sum);
                        default: n_c0 = r_c0;
                    endcase
                    if (r_op != OP_LAST) begin
                        n_op = r_op + 1'b1;
                        n_state = S_LOAD;
                    end else begin
                        n_op = '0;
                        if (r_job == JOB_DET) begin
                            n_det = acc_sum;
                            if (acc_sum == '0) begin
                                n_sing = 1'b1;
                                n_state = S_DONE;
                            end else begin
                                n_job = r_job + 1'b1;
                                n_state = S_LOAD;
                            end
                        end else begin
                            n_neg = acc_sum[DW-1] ^ r_det[DW-1];
                            n_num = {num_abs[MW-1:0], {afit_pkg::FRAC_BITS{1'b0}}};
                            n_den = det_abs[MW-1:0];
                            n_rem = '0;
                            n_q = '0;
                            n_cnt = '0;
                            n_state = S_DIV;
                        end
                    end
                end
            end
            S_DIV: begin
                n_rem = ge ? MW'(rs - {1'b0, r_den}) : rs[MW-1:0];
                n_num = r_num << 1;
                n_q = {r_q[NW-2:0], ge};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == afit_pkg::STEP_W'(NW - 1)) begin
                    n_state = S_RND;
                end
            end
            S_RND: begin
                n_coef[r_job - 3'd1] = res;
                if (q1 > lim) begin
                    n_sat = 1'b1;
                end
                if (r_job == JOB_LAST) begin
                    n_state = S_DONE;
                end else begin
                    n_job = r_job + 1'b1;
                    n_state = S_LOAD;
                end
            end
            S_DONE: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fit  <= n_fit;
        r_job  <= n_job;
        r_op   <= n_op;
        r_cnt  <= n_cnt;
        r_acc  <= n_acc;
        r_ma   <= n_ma;
        r_mb   <= n_mb;
        r_det  <= n_det;
        r_c0   <= n_c0;
        r_c1   <= n_c1;
        r_c2   <= n_c2;
        r_neg  <= n_neg;
        r_num  <= n_num;
        r_den  <= n_den;
        r_rem  <= n_rem;
        r_q    <= n_q;
        r_coef <= n_coef;
        r_sing <= n_sing;
        r_sat  <= n_sat;
    end
endmodule
`default_nettype wire

[rtl/affine_least_squares_fit.sv]
// Top level of the affine least-squares fit block.
// Pairs are taken one per cycle into a four-entry queue while it is not full, and
// summed into exact normal-equation accumulators at one pair per cycle unless a
// last pair waits for the solver. A pair marked last hands the sums to the solver,
// which computes seven 3x3 determinants with a shift-add multiplier (9 products
// each) and six restoring divisions; when the matrix is singular it stops after
// the first determinant. Pairs of the next set keep flowing in during a solve;
// only the next last pair waits until the previous result is taken.
`default_nettype none
module affine_least_squares_fit (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_valid,
    output logic                            o_ready,
    input  wire [afit_pkg::IN_W-1:0]        i_src_x,
    input  wire [afit_pkg::IN_W-1:0]        i_src_y,
    input  wire [afit_pkg::IN_W-1:0]        i_dst_x,
    input  wire [afit_pkg::IN_W-1:0]        i_dst_y,
    input  wire                             i_last_pair,
    output logic                            o_valid,
    input  wire                             i_ready,
    output logic signed [afit_pkg::OUT_W-1:0] o_coef_dy_from_sy,
    output logic signed [afit_pkg::OUT_W-1:0] o_coef_dy_from_sx,
    output logic signed [afit_pkg::OUT_W-1:0] o_coef_dy_offset,
    output logic signed [afit_pkg::OUT_W-1:0] o_coef_dx_from_sy,
    output logic signed [afit_pkg::OUT_W-1:0] o_coef_dx_from_sx,
    output logic signed [afit_pkg::OUT_W-1:0] o_coef_dx_offset,
    output logic                            o_singular,
    output logic                            o_overflow,
    output logic                            o_saturated
);
    afit_pkg::t_item w_push_item, w_pop_item;
    afit_pkg::t_fit  w_fit;
    logic w_push, w_full, w_qvalid, w_pop, w_idle, w_start;
    logic signed [afit_pkg::OUT_W-1:0] w_coef [6];

    afit_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_src_x     (i_src_x),
        .i_src_y     (i_src_y),
        .i_dst_x     (i_dst_x),
        .i_dst_y     (i_dst_y),
        .i_last_pair (i_last_pair),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_item      (w_push_item)
    );

    afit_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_qvalid),
        .o_item  (w_pop_item)
    );

    afit_acc u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_qvalid),
        .i_item  (w_pop_item),
        .o_pop   (w_pop),
        .i_idle  (w_idle),
        .o_start (w_start),
        .o_fit   (w_fit)
    );

    afit_solve u_solve (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_fit       (w_fit),
        .o_idle      (w_idle),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_coef      (w_coef),
        .o_singular  (o_singular),
        .o_overflow  (o_overflow),
        .o_saturated (o_saturated)
    );

    assign o_coef_dy_from_sy = w_coef[0];
    assign o_coef_dy_from_sx = w_coef[1];
    assign o_coef_dy_offset  = w_coef[2];
    assign o_coef_dx_from_sy = w_coef[3];
    assign o_coef_dx_from_sx = w_coef[4];
    assign o_coef_dx_offset  = w_coef[5];

    a_start_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |-> w_idle)
        else $error("solve started while solver busy");

    a_valid_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !w_idle)
        else $error("result shown while solver idle");

    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_singular) |-> (o_coef_dy_from_sy == '0 && o_coef_dy_from_sx == '0
            && o_coef_dy_offset == '0 && o_coef_dx_from_sy == '0
            && o_coef_dx_from_sx == '0 && o_coef_dx_offset == '0 && !o_saturated))
        else $error("singular result with nonzero coefficients");
endmodule
`default_nettype wire

[tb/sv/affine_least_squares_fit_test.sv]
// Self-checking testbench: directed table and random point sets against an exact predictor.
`default_nettype none
module affine_least_squares_fit_test;
    typedef logic signed [159:0] t_wide;

    typedef struct {
        logic signed [afit_pkg::OUT_W-1:0] coef [6];
        logic                    singular;
        logic                    overflow;
        logic                    saturated;
    } t_fit_result;

    typedef struct {
        logic [afit_pkg::IN_W-1:0] sx, sy, dx, dy;
        logic            last;
        logic            typed;
        t_fit_result     res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [afit_pkg::IN_W-1:0] i_src_x = '0, i_src_y = '0, i_dst_x = '0, i_dst_y = '0;
    logic i_last_pair = 1'b0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic signed [afit_pkg::OUT_W-1:0] o_coef [6];
    logic o_singular, o_overflow, o_saturated;

    affine_least_squares_fit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_src_x(i_src_x), .i_src_y(i_src_y), .i_dst_x(i_dst_x), .i_dst_y(i_dst_y),
        .i_last_pair(i_last_pair), .o_valid(o_valid), .i_ready(i_ready),
        .o_coef_dy_from_sy(o_coef[0]), .o_coef_dy_from_sx(o_coef[1]),
        .o_coef_dy_offset(o_coef[2]), .o_coef_dx_from_sy(o_coef[3]),
        .o_coef_dx_from_sx(o_coef[4]), .o_coef_dx_offset(o_coef[5]),
        .o_singular(o_singular), .o_overflow(o_overflow), .o_saturated(o_saturated)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // exact normal-equation sums kept by the predictor
    logic [63:0] acc_syy, acc_sxy, acc_sxx, acc_sy, acc_sx, acc_n;
    logic [63:0] acc_dy_sy, acc_dy_sx, acc_dy, acc_dx_sy, acc_dx_sx, acc_dx;
    logic        acc_ovf;

    t_fit_result pending_fits [$];
    int  errors = 0;
    int  idle_cycles = 0;
    bit  quiet_mode = 0;
    bit  long_hold_req = 0;
    bit  stim_done = 0;

    function automatic t_wide det3(input t_wide a, b, c, d, e, f, g, h, k);
        return a * (e * k - f * h) - b * (d * k - f * g) + c * (d * h - e * g);
    endfunction

    function automatic logic signed [afit_pkg::OUT_W-1:0] coef_q(input t_wide num,
                                                                 input t_wide den,
                                                                 inout logic sat);
        logic        neg;
        logic [159:0] an, ad, q, lim;
        neg = (num < 0) != (den < 0);
        an  = (num < 0) ? -num : num;
        ad  = (den < 0) ? -den : den;
        q   = ((an << (afit_pkg::FRAC_BITS + 1)) + ad) / (ad << 1);
        lim = neg ? 160'h8000_0000 : 160'h7FFF_FFFF;
        if (q > lim) begin
            q   = lim;
            sat = 1'b1;
        end
        return neg ? -q[afit_pkg::OUT_W-1:0] : q[afit_pkg::OUT_W-1:0];
    endfunction

    function automatic bit fit_differs(input t_fit_result a, input t_fit_result b);
        bit d;
        d = (a.singular !== b.singular) || (a.overflow !== b.overflow)
            || (a.saturated !== b.saturated);
        for (int i = 0; i < 6; i++)
            if (a.coef[i] !== b.coef[i]) d = 1;
        return d;
    endfunction

    function automatic void clear_sums();
        {acc_syy, acc_sxy, acc_sxx, acc_sy, acc_sx, acc_n} = '0;
        {acc_dy_sy, acc_dy_sx, acc_dy, acc_dx_sy, acc_dx_sx, acc_dx} = '0;
        acc_ovf = 1'b0;
    endfunction

    // advance the sums by one pair; return 1 with the fit when the pair closes a set
    function automatic bit fit_step(input logic [afit_pkg::IN_W-1:0] sx, sy, dx, dy,
                                    input logic last, output t_fit_result r);
        t_wide m [9];
        t_wide bv [3];
        t_wide t [9];
        t_wide det;
        logic  sat;
        if (acc_n < afit_pkg::MAX_POINTS) begin
            acc_syy += sy * sy;  acc_sxy += sx * sy;  acc_sxx += sx * sx;
            acc_sy += sy;  acc_sx += sx;  acc_n += 1;
            acc_dy_sy += dy * sy;  acc_dy_sx += dy * sx;  acc_dy += dy;
            acc_dx_sy += dx * sy;  acc_dx_sx += dx * sx;  acc_dx += dx;
        end else begin
            acc_ovf = 1'b1;
        end
        if (!last) return 0;
        m = '{t_wide'(acc_syy), t_wide'(acc_sxy), t_wide'(acc_sy),
              t_wide'(acc_sxy), t_wide'(acc_sxx), t_wide'(acc_sx),
              t_wide'(acc_sy), t_wide'(acc_sx), t_wide'(acc_n)};
        det = det3(m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7], m[8]);
        sat = 1'b0;
        for (int i = 0; i < 6; i++) r.coef[i] = '0;
        r.singular = (det == 0);
        if (det != 0) begin
            for (int s = 0; s < 2; s++) begin
                if (s == 0) bv = '{t_wide'(acc_dy_sy), t_wide'(acc_dy_sx), t_wide'(acc_dy)};
                else        bv = '{t_wide'(acc_dx_sy), t_wide'(acc_dx_sx), t_wide'(acc_dx)};
                for (int c = 0; c < 3; c++) begin
                    t = m;
                    for (int k = 0; k < 3; k++) t[k*3+c] = bv[k];
                    r.coef[s*3+c] = coef_q(det3(t[0], t[1], t[2], t[3], t[4], t[5],
                                                t[6], t[7], t[8]), det, sat);
                end
            end
        end
        r.overflow  = acc_ovf;
        r.saturated = sat;
        clear_sums();
        return 1;
    endfunction

    function automatic int pick_gap();
        int p;
        if (quiet_mode) return 0;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_pair(input logic [afit_pkg::IN_W-1:0] sx, sy, dx, dy,
                             input logic last, input bit typed, input t_fit_result want);
        t_fit_result r;
        i_valid     <= 1'b1;
        i_src_x     <= sx;  i_src_y <= sy;
        i_dst_x     <= dx;  i_dst_y <= dy;
        i_last_pair <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (fit_step(sx, sy, dx, dy, last, r)) begin
            if (typed) begin
                if (fit_differs(r, want)) begin
                    $display("%0t: typed row expected coef0 %0d singular %b got %0d %b",
                             $time, want.coef[0], want.singular, r.coef[0], r.singular);
                    errors++;
                end
                pending_fits.insert(pending_fits.size(), want);
            end else begin
                pending_fits.insert(pending_fits.size(), r);
            end
        end
        repeat (pick_gap()) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic send_set(input int n, input bit near_line);
        logic [afit_pkg::IN_W-1:0] sx, sy, dx, dy;
        t_fit_result none;
        for (int i = 0; i < n; i++) begin
            if (near_line) begin
                sx = afit_pkg::IN_W'($urandom_range(0, 4095));
                sy = afit_pkg::IN_W'((sx >> 1) + $urandom_range(0, 1));
            end else begin
                sx = afit_pkg::IN_W'($urandom);  sy = afit_pkg::IN_W'($urandom);
            end
            dx = afit_pkg::IN_W'($urandom);  dy = afit_pkg::IN_W'($urandom);
            send_pair(sx, sy, dx, dy, i == n - 1, 0, none);
        end
    endtask

    t_row rows [$];

    function automatic t_fit_result typed_fit(input int c0, c1, c2, c3, c4, c5,
                                              input logic sg, ov, st);
        t_fit_result r;
        r.coef = '{c0, c1, c2, c3, c4, c5};
        r.singular = sg;  r.overflow = ov;  r.saturated = st;
        return r;
    endfunction

    function automatic void add_row(input int sx, sy, dx, dy, input bit last,
                                    input bit typed, input t_fit_result r);
        t_row w;
        w.sx = afit_pkg::IN_W'(sx);  w.sy = afit_pkg::IN_W'(sy);
        w.dx = afit_pkg::IN_W'(dx);  w.dy = afit_pkg::IN_W'(dy);
        w.last = last;  w.typed = typed;  w.res = r;
        rows.insert(rows.size(), w);
    endfunction

    initial begin
        t_fit_result sing, none, ident;
        int items;
        clear_sums();
        sing  = typed_fit(0, 0, 0, 0, 0, 0, 1, 0, 0);
        none  = sing;
        ident = typed_fit(65536, 0, 0, 0, 65536, 0, 0, 0, 0);
        add_row(0, 0, 0, 0, 1, 1, sing);
        add_row(4095, 4095, 4095, 4095, 1, 1, sing);
        add_row(4095, 0, 0, 4095, 0, 0, none);
        add_row(0, 4095, 4095, 0, 1, 1, sing);
        add_row(0, 0, 0, 0, 0, 0, none);
        add_row(1, 0, 1, 0, 0, 0, none);
        add_row(0, 1, 0, 1, 1, 1, ident);
        add_row(0, 0, 4095, 4095, 0, 0, none);
        add_row(4095, 0, 0, 0, 0, 0, none);
        add_row(0, 4095, 4095, 0, 1, 0, none);
        add_row(0, 0, 0, 0, 0, 0, none);
        add_row(4095, 1, 4095, 4095, 0, 0, none);
        add_row(4094, 1, 0, 0, 1, 0, none);
        add_row(1, 1, 1, 1, 0, 0, none);
        add_row(2, 2, 2, 2, 0, 0, none);
        add_row(3, 3, 3, 3, 1, 1, sing);
        add_row(2730, 1365, 3003, 100, 0, 0, none);
        add_row(1365, 2730, 100, 3003, 0, 0, none);
        add_row(3071, 511, 2048, 4095, 0, 0, none);
        add_row(7, 3000, 4000, 9, 1, 0, none);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i])
            send_pair(rows[i].sx, rows[i].sy, rows[i].dx, rows[i].dy, rows[i].last,
                      rows[i].typed, rows[i].res);

        // overflow: a set longer than the pair limit
        long_hold_req = 1;
        send_set(afit_pkg::MAX_POINTS + 40, 0);

        items = 0;
        while (items < 900) begin
            int n;
            quiet_mode = ($urandom_range(0, 9) == 0);
            if (items > 400 && items < 420) begin
                i_valid <= 1'b0;
                while (pending_fits.size() != 0) @(posedge i_clk);
            end
            case ($urandom_range(0, 9))
                0:       n = $urandom_range(1, 2);
                1:       n = $urandom_range(3, 4);
                default: n = $urandom_range(3, 16);
            endcase
            send_set(n, $urandom_range(0, 7) == 0);
            items += n;
        end
        i_valid <= 1'b0;
        stim_done = 1;
    end

    initial begin
        int hold;
        bit held = 0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req && !held && i_rst_n) begin
                held = 1;
                i_ready <= 1'b0;
                repeat (6000) @(posedge i_clk);
            end
            hold = pick_gap();
            if (hold == 0) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b0;
                repeat (hold - 1) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_fit_result want;
        if (o_valid && i_ready && i_rst_n) begin
            if (pending_fits.size() == 0) begin
                $display("%0t: unexpected result", $time);
                errors++;
            end else begin
                want = pending_fits.pop_front();
                for (int i = 0; i < 6; i++)
                    if (o_coef[i] !== want.coef[i]) begin
                        $display("%0t: coef %0d expected %0d got %0d", $time, i,
                                 want.coef[i], o_coef[i]);
                        errors++;
                    end
                if (o_singular !== want.singular) begin
                    $display("%0t: singular expected %b got %b", $time,
                             want.singular, o_singular);
                    errors++;
                end
                if (o_overflow !== want.overflow) begin
                    $display("%0t: overflow expected %b got %b", $time,
                             want.overflow, o_overflow);
                    errors++;
                end
                if (o_saturated !== want.saturated) begin
                    $display("%0t: saturated expected %b got %b", $time,
                             want.saturated, o_saturated);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 50000) begin
            $display("affine_least_squares_fit: mismatch");
            $finish;
        end
    end

    initial begin
        wait (stim_done);
        while (pending_fits.size() != 0) @(posedge i_clk);
        repeat (4000) @(posedge i_clk);
        if (errors == 0 && pending_fits.size() == 0) begin
            $display("affine_least_squares_fit: match");
        end else begin
            $display("affine_least_squares_fit: mismatch");
        end
        $finish;
    end
endmodule
`default_nettype wire

[sim.f]
rtl/afit_pkg.sv
rtl/afit_front.sv
rtl/afit_fifo.sv
rtl/afit_acc.sv
rtl/afit_solve.sv
rtl/affine_least_squares_fit.sv
tb/sv/affine_least_squares_fit_test.sv
